[design/rm2eul_pkg.sv]
// Shared types, constants and helper functions for the rotation-matrix to Euler-angle core.
// No dependencies; every other design file imports this package.
package rm2eul_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;

  // Width of a CORDIC input operand (signed), of its x/y datapath and of its angle accumulator.
  localparam int IN_W = 34;
  localparam int CW   = 36;
  localparam int ZW   = 26;

  // Width of the gain-corrected magnitude (unsigned Q3.30).
  localparam int SYW  = 33;

  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1074;

  localparam int ANGLE_LIMIT  = 23040;
  localparam int DEG180_Q16   = 11796480;
  localparam int INV_GAIN_Q30 = 652032874;

  typedef struct packed {
    logic signed [31:0] entry_0;
    logic signed [31:0] entry_1;
    logic signed [31:0] entry_2;
    logic signed [31:0] entry_5;
    logic signed [31:0] entry_6;
    logic signed [31:0] entry_9;
    logic signed [31:0] entry_10;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic               singular;
  } out_item_t;

  // atan(2^-i) in degrees, Q16.
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    int v;
    case (i)
      0:  v = 2949120;
      1:  v = 1740967;
      2:  v = 919879;
      3:  v = 466945;
      4:  v = 234379;
      5:  v = 117304;
      6:  v = 58666;
      7:  v = 29335;
      8:  v = 14668;
      9:  v = 7334;
      10: v = 3667;
      11: v = 1833;
      12: v = 917;
      13: v = 458;
      14: v = 229;
      15: v = 115;
      16: v = 57;
      17: v = 29;
      18: v = 14;
      19: v = 7;
      20: v = 4;
      21: v = 2;
      22: v = 1;
      default: v = 0;
    endcase
    return ZW'(v);
  endfunction

  // Round the Q16 degree accumulator to 1/128 degree and clamp to +-180.
  function automatic logic signed [15:0] quant_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    logic signed [ZW-10:0] q;
    logic signed [15:0]    res;
    r = z + ZW'(256);
    q = r[ZW-1:9];
    if (q > ANGLE_LIMIT) begin
      res = 16'(ANGLE_LIMIT);
    end else if (q < -ANGLE_LIMIT) begin
      res = -16'(ANGLE_LIMIT);
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

[design/rm2eul_cordic.sv]
// Pipelined CORDIC in vectoring mode: a pre-rotation stage, then one micro-rotation per register stage.
// Depends on rm2eul_pkg.
module rm2eul_cordic #(
  parameter int ITER = rm2eul_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [rm2eul_pkg::IN_W-1:0]  y_in,
  input  logic signed [rm2eul_pkg::IN_W-1:0]  x_in,
  output logic signed [rm2eul_pkg::CW-1:0]    x_out,
  output logic signed [rm2eul_pkg::ZW-1:0]    z_out
);
  import rm2eul_pkg::*;

  logic signed [CW-1:0] x_s [0:ITER];
  logic signed [CW-1:0] y_s [0:ITER];
  logic signed [ZW-1:0] z_s [0:ITER];
  logic                 zero_s [0:ITER];

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] x0_next, y0_next;
  logic signed [ZW-1:0] z0_next;

  // Pre-rotation into the right half plane.
  always_comb begin
    xe = CW'(x_in);
    ye = CW'(y_in);
    x0_next = xe;
    y0_next = ye;
    z0_next = '0;
    if (xe < 0) begin
      x0_next = -xe;
      y0_next = -ye;
      z0_next = (ye >= 0) ? ZW'(DEG180_Q16) : -ZW'(DEG180_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_s[0]    <= x0_next;
      y_s[0]    <= y0_next;
      z_s[0]    <= z0_next;
      zero_s[0] <= (xe == 0) && (ye == 0);
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_s[i+1] <= zero_s[i];
        if (y_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_entry(i);
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_entry(i);
        end
      end
    end
  end

  // Zero vector: angle and magnitude are both zero.
  assign x_out = zero_s[ITER] ? '0 : x_s[ITER];
  assign z_out = zero_s[ITER] ? '0 : z_s[ITER];

endmodule

[design/rotation_matrix_to_euler_angles_core.sv]
// Top level of the rotation-matrix to Euler-angle (x-y-z) core.
// Depends on rm2eul_pkg and rm2eul_cordic.
//
// Converts seven Q2.30 entries of a rotation matrix into roll, pitch and yaw in 1/128 degree
// plus a gimbal-lock flag. The core is fully pipelined: one transaction can enter in every
// clock cycle while the output is not stalled. The datapath holds two CORDIC chains in series:
// the yaw CORDIC (which also yields the magnitude sy), a two-stage split multiply for the gain
// correction, one stage for the threshold compare and operand selection, then the pitch and
// roll CORDICs side by side, and two stages of rounding, clamping and negation. A stall at the
// output freezes the whole pipeline, so in_stall follows out_valid && out_stall. The threshold
// register may be rewritten only while no transaction is in flight.
module rotation_matrix_to_euler_angles_core #(
  parameter int CORDIC_ITERATIONS = rm2eul_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rm2eul_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rm2eul_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [rm2eul_pkg::THR_W-1:0]      cfg_wdata
);
  import rm2eul_pkg::*;

  localparam int L   = CORDIC_ITERATIONS + 1;
  localparam int NST = 2 * L + 5;

  typedef struct packed {
    logic signed [31:0] e2;
    logic signed [31:0] e5;
    logic signed [31:0] e6;
    logic signed [31:0] e9;
    logic signed [31:0] e10;
  } ent_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic               sing;
  } carry_t;

  logic             adv;
  logic [NST-1:0]   vld;
  logic [THR_W-1:0] threshold;

  // Advance everything unless a finished result is held back.
  assign adv      = !(vld[NST-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Phase 1: yaw CORDIC on (e1, e0); carry the other entries alongside.
  logic signed [CW-1:0] a_x;
  logic signed [ZW-1:0] a_z;

  rm2eul_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_yaw (
    .clk   (clk),
    .adv   (adv),
    .y_in  (IN_W'(in_data.entry_1)),
    .x_in  (IN_W'(in_data.entry_0)),
    .x_out (a_x),
    .z_out (a_z)
  );

  ent_t d_ent [0:L-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ent[0] <= '{e2: in_data.entry_2, e5: in_data.entry_5, e6: in_data.entry_6,
                    e9: in_data.entry_9, e10: in_data.entry_10};
      for (int k = 1; k < L; k++) begin
        d_ent[k] <= d_ent[k-1];
      end
    end
  end

  // M1: split gain-correction multiply, round the yaw angle.
  localparam int HW = CW / 2;
  logic [HW+29:0]     m1_plo, m1_phi;
  logic signed [15:0] m1_yaw;
  ent_t               m1_ent;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_plo <= (HW+30)'(a_x[HW-1:0]) * (HW+30)'(INV_GAIN_Q30);
      m1_phi <= (HW+30)'(a_x[CW-1:HW]) * (HW+30)'(INV_GAIN_Q30);
      m1_yaw <= quant_angle(a_z);
      m1_ent <= d_ent[L-1];
    end
  end

  // M2: sum the partial products, round to Q3.30.
  logic [HW+HW+30:0]  m2_sum;
  logic [SYW-1:0]     m2_sy;
  logic signed [15:0] m2_yaw;
  ent_t               m2_ent;

  assign m2_sum = ((HW+HW+31)'(m1_phi) << HW) + (HW+HW+31)'(m1_plo) + (HW+HW+31)'(1 << 29);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_sy  <= m2_sum[SYW+29:30];
      m2_yaw <= m1_yaw;
      m2_ent <= m1_ent;
    end
  end

  // M3: gimbal-lock decision and operand selection for phase 2.
  logic                   sing;
  logic signed [IN_W-1:0] m3_py, m3_px, m3_ry, m3_rx;
  carry_t                 m3_carry;

  assign sing = m2_sy < SYW'(threshold);

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_py    <= -IN_W'(m2_ent.e2);
      m3_px    <= IN_W'(m2_sy);
      m3_ry    <= sing ? -IN_W'(m2_ent.e9) : IN_W'(m2_ent.e6);
      m3_rx    <= sing ? IN_W'(m2_ent.e5) : IN_W'(m2_ent.e10);
      m3_carry <= '{yaw: sing ? 16'sd0 : m2_yaw, sing: sing};
    end
  end

  // Phase 2: pitch and roll CORDICs side by side.
  logic signed [CW-1:0] p_x, r_x;
  logic signed [ZW-1:0] p_z, r_z;

  rm2eul_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_pitch (
    .clk   (clk),
    .adv   (adv),
    .y_in  (m3_py),
    .x_in  (m3_px),
    .x_out (p_x),
    .z_out (p_z)
  );

  rm2eul_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_roll (
    .clk   (clk),
    .adv   (adv),
    .y_in  (m3_ry),
    .x_in  (m3_rx),
    .x_out (r_x),
    .z_out (r_z)
  );

  carry_t d_carry [0:L-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_carry[0] <= m3_carry;
      for (int k = 1; k < L; k++) begin
        d_carry[k] <= d_carry[k-1];
      end
    end
  end

  // F1: round and clamp. F2: negate roll into the output register.
  logic signed [15:0] f1_pitch, f1_roll;
  carry_t             f1_carry;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_pitch <= quant_angle(p_z);
      f1_roll  <= quant_angle(r_z);
      f1_carry <= d_carry[L-1];
      out_data <= '{roll_deg: -f1_roll, pitch_deg: f1_pitch, yaw_deg: f1_carry.yaw,
                    singular: f1_carry.sing};
    end
  end

  assign out_valid = vld[NST-1];

  // Magnitudes of the CORDIC x outputs are never used beyond phase 1.
  logic unused_x;
  assign unused_x = ^{p_x, r_x};

  a_sing_yaw_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.singular |-> out_data.yaw_deg == 16'sd0)
    else $error("yaw not forced to zero in gimbal lock");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pitch_deg <= 16'sd23040 && out_data.pitch_deg >= -16'sd23040)
    else $error("pitch outside clamp range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vld))
    else $error("pipeline moved while output stalled");

endmodule
